FILE: rtl/jpr_pkg.sv
// Package for the joystick packet receiver: payload structs, command codes, status
// and register codes, controller/datapath command and status structs and the float32 converter. No dependencies.
package jpr_pkg;

  localparam int unsigned CfgWidth = 24;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned NumAxes = 4;
  localparam int unsigned NumButtons = 5;
  localparam int unsigned ButtonBase = 19;
  localparam int unsigned DivBits = 32;

  typedef enum logic [1:0] {
    CmdByte  = 2'd0,
    CmdLatch = 2'd1,
    CmdClear = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusChecksum = 2'd1,
    StatusAddress  = 2'd2,
    StatusUnused   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RegNodeAddress = 2'd0,
    RegCheckEnable = 2'd1,
    RegDeadZone    = 2'd2,
    RegUnused      = 2'd3
  } reg_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic       packet_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] throttle;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic [7:0]         arm_button;
    logic [7:0]         flip_button;
    logic [7:0]         flight_mode;
    logic [7:0]         altitude_mode;
    logic [7:0]         proactive_flag;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic       take_byte;   // store byte, update sum/position
    logic       latch_bias;
    logic       clear_bias;
    logic       load_packet; // convert floats, capture buttons (status ok)
    logic       start_axis;  // start normalizing axis ax_sel
    logic [1:0] ax_sel;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       last_byte;   // taken byte closes the packet
    logic [1:0] status;
    logic       axis_done;
  } dp_stat_t;

  // Float32 to Q1.15, round half away, saturate, NaN to 0.
  function automatic logic signed [15:0] f2q(input logic [31:0] bits, input logic negate);
    logic        neg;
    logic [7:0]  ex;
    logic [23:0] m;
    logic [7:0]  s;
    logic [24:0] sum;
    logic [16:0] mag;
    logic signed [17:0] v;
    neg = bits[31] ^ negate;
    ex = bits[30:23];
    m = (ex == 8'd0) ? {1'b0, bits[22:0]} : {1'b1, bits[22:0]};
    s = 8'd135 - ((ex == 8'd0) ? 8'd1 : ex);
    sum = 25'd0;
    mag = 17'd0;
    if (ex >= 8'd127) begin
      mag = 17'd32768;
    end else if (s > 8'd25) begin
      mag = 17'd0;
    end else begin
      sum = ({1'b0, m} + (25'd1 << (s - 8'd1))) >> s;
      mag = sum[16:0];
    end
    v = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    if (ex == 8'hFF && bits[22:0] != 23'd0) f2q = 16'sd0;
    else if (v > 18'sd32767) f2q = 16'sh7FFF;
    else if (v < -18'sd32768) f2q = 16'sh8000;
    else f2q = v[15:0];
  endfunction

endpackage

FILE: rtl/jpr_div.sv
// Iterative restoring divider, one quotient bit per cycle, unsigned.
// Depends on jpr_pkg.
module jpr_div import jpr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DivBits-1:0]  num_i,
  input  logic [DivBits-1:0]  den_i,
  output logic                done_o,
  output logic [DivBits-1:0]  quo_o
);
  localparam int unsigned CntW = $clog2(DivBits + 1);
  logic [DivBits-1:0] quo_q, quo_d, den_q, den_d;
  logic [DivBits:0]   rem_q, rem_d, trial;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;

  always_comb begin
    quo_d = quo_q;
    den_d = den_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = {rem_q[DivBits-1:0], quo_q[DivBits-1]} - {1'b0, den_q};
    if (start_i) begin
      quo_d = num_i;
      den_d = den_i;
      rem_d = '0;
      cnt_d = CntW'(DivBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DivBits]) begin
        rem_d = trial;
        quo_d = {quo_q[DivBits-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DivBits-1:0], quo_q[DivBits-1]};
        quo_d = {quo_q[DivBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o = quo_q;
endmodule

FILE: rtl/jpr_datapath.sv
// Datapath: packet store, checksum, float conversion, bias and normalization.
// Depends on jpr_pkg and jpr_div.
module jpr_datapath import jpr_pkg::*; #(
  parameter int unsigned PACKET_BYTES = 25
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  input  in_item_t             item_i,
  input  logic [23:0]          node_address_i,
  input  logic                 check_enable_i,
  input  logic [14:0]          dead_zone_i,
  output dp_stat_t             stat_o,
  output out_item_t            result_o
);
  localparam int unsigned PosW = $clog2(PACKET_BYTES + 1);

  logic [7:0] store_q [PACKET_BYTES];
  logic [PosW-1:0] pos_q, pos_d, pos_now;
  logic [7:0] sum_q, sum_d, sum_now;
  logic signed [15:0] raw_q [NumAxes];
  logic signed [15:0] bias_q [NumAxes];
  logic signed [15:0] norm_q [NumAxes];
  logic bias_valid_q;
  logic [7:0] btn_q [NumButtons];
  logic [1:0] status_q, status_d;
  logic last;

  always_comb begin
    pos_now = item_i.packet_start ? '0 : pos_q;
    sum_now = item_i.packet_start ? 8'd0 : sum_q;
    if (pos_now >= PosW'(PACKET_BYTES)) pos_now = '0;
    last = (pos_now == PosW'(PACKET_BYTES - 1));
    pos_d = last ? '0 : pos_now + PosW'(1);
    sum_d = last ? 8'd0 : sum_now + item_i.data_byte;
    status_d = StatusOk;
    if (check_enable_i) begin
      if (sum_now != item_i.data_byte) status_d = StatusChecksum;
      else if (store_q[0] != node_address_i[23:16] || store_q[1] != node_address_i[15:8]
               || store_q[2] != node_address_i[7:0]) status_d = StatusAddress;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
      status_q <= StatusOk;
    end else if (cmd_i.take_byte) begin
      pos_q <= pos_d;
      sum_q <= sum_d;
      if (last) status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte) store_q[pos_now[PosW-1:0] < PosW'(PACKET_BYTES) ? pos_now : '0]
        <= item_i.data_byte;
  end

  // axis offsets: yaw 3, throttle 7, roll 11, pitch 15
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumAxes; i++) begin
        raw_q[i] <= '0;
        bias_q[i] <= '0;
      end
      for (int i = 0; i < NumButtons; i++) btn_q[i] <= '0;
      bias_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_packet) begin
        for (int i = 0; i < NumAxes; i++) begin
          raw_q[i] <= f2q({store_q[4*i+6], store_q[4*i+5], store_q[4*i+4], store_q[4*i+3]},
                          i == 3);
        end
        for (int i = 0; i < NumButtons; i++) btn_q[i] <= store_q[ButtonBase + i];
      end
      if (cmd_i.latch_bias) begin
        for (int i = 0; i < NumAxes; i++) bias_q[i] <= raw_q[i];
        bias_valid_q <= 1'b1;
      end else if (cmd_i.clear_bias) begin
        for (int i = 0; i < NumAxes; i++) bias_q[i] <= '0;
        bias_valid_q <= 1'b0;
      end
    end
  end

  // normalization of one axis, divide via shared unit
  // denominator reaches 131072 at full-scale bias, so it needs 19 bits
  logic signed [17:0] diff, dz;
  logic signed [18:0] den_s;
  logic signed [18:0] num_s;
  logic               up, down, den_bad, neg_q;
  logic [1:0]         ax_q;
  logic signed [15:0] direct_q;
  logic [DivBits-1:0] quo;
  logic               div_done;
  logic [33:0]        num_mag;

  always_comb begin
    dz = $signed({3'b0, dead_zone_i});
    diff = 18'(raw_q[cmd_i.ax_sel]) - 18'(bias_q[cmd_i.ax_sel]);
    up = diff > dz;
    down = diff < -dz;
    den_s = up ? 19'sd65536 - (19'(bias_q[cmd_i.ax_sel]) <<< 1) - 19'(dz)
               : 19'sd65536 + (19'(bias_q[cmd_i.ax_sel]) <<< 1) - 19'(dz);
    den_bad = den_s <= 19'sd0;
    num_s = up ? 19'(diff - dz) : 19'(-(diff + dz));
    num_mag = {num_s[16:0], 16'd0, 1'b0} >> 1;
  end

  jpr_div u_div (
    .clk_i, .rst_ni,
    .start_i(cmd_i.start_axis && bias_valid_q && (up || down) && !den_bad),
    .num_i(num_mag[DivBits-1:0]),
    .den_i(DivBits'(unsigned'(den_s))),
    .done_o(div_done),
    .quo_o(quo)
  );

  logic norm_wr;
  logic signed [15:0] norm_val;
  logic direct_done_q;
  always_comb begin
    norm_wr = 1'b0;
    norm_val = direct_q;
    if (direct_done_q) norm_wr = 1'b1;
    else if (div_done) begin
      norm_wr = 1'b1;
      if (neg_q) norm_val = (quo > 32'd32768) ? 16'sh8000 : 16'(-quo);
      else norm_val = (quo > 32'd32767) ? 16'sh7FFF : quo[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direct_done_q <= 1'b0;
    end else begin
      direct_done_q <= cmd_i.start_axis && !(bias_valid_q && (up || down) && !den_bad);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_axis) begin
      ax_q <= cmd_i.ax_sel;
      neg_q <= down && !up;
      if (!bias_valid_q) direct_q <= raw_q[cmd_i.ax_sel];
      else if (up) direct_q <= 16'sh7FFF;
      else if (down) direct_q <= 16'sh8000;
      else direct_q <= 16'sd0;
    end
    if (norm_wr) norm_q[ax_q] <= norm_val;
  end

  assign stat_o.last_byte = last;
  assign stat_o.status = status_q;
  assign stat_o.axis_done = norm_wr;

  always_comb begin
    result_o.status = status_q;
    result_o.yaw = norm_q[0];
    result_o.throttle = norm_q[1];
    result_o.roll = norm_q[2];
    result_o.pitch = norm_q[3];
    result_o.arm_button = btn_q[0];
    result_o.flip_button = btn_q[1];
    result_o.flight_mode = btn_q[2];
    result_o.altitude_mode = btn_q[3];
    result_o.proactive_flag = btn_q[4];
  end
endmodule

FILE: rtl/jpr_ctrl.sv
// Controller state machine: accepts transactions, sequences axis normalization,
// presents the result. Depends on jpr_pkg.
module jpr_ctrl import jpr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_item_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);
  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StLoad = 5'b00010,
    StAxis = 5'b00100,
    StWait = 5'b01000,
    StOut  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] ax_q, ax_d;
  logic accept;

  assign in_stall_o = (state_q != StIdle);
  assign accept = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == StOut);

  always_comb begin
    state_d = state_q;
    ax_d = ax_q;
    cmd_o = '0;
    cmd_o.ax_sel = ax_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (in_item_i.cmd)
            CmdByte: begin
              cmd_o.take_byte = 1'b1;
              if (stat_i.last_byte) state_d = StLoad;
            end
            CmdLatch: cmd_o.latch_bias = 1'b1;
            CmdClear: cmd_o.clear_bias = 1'b1;
            default: ;
          endcase
        end
      end
      StLoad: begin
        cmd_o.load_packet = (stat_i.status == StatusOk);
        ax_d = '0;
        state_d = StAxis;
      end
      StAxis: begin
        cmd_o.start_axis = 1'b1;
        state_d = StWait;
      end
      StWait: begin
        if (stat_i.axis_done) begin
          ax_d = ax_q + 2'd1;
          state_d = (ax_q == 2'd3) ? StOut : StAxis;
        end
      end
      StOut: if (!out_stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ax_q <= '0;
    end else begin
      state_q <= state_d;
      ax_q <= ax_d;
    end
  end
endmodule

FILE: rtl/joystick_packet_receiver_unit.sv
// Joystick packet receiver top level: config registers, controller, datapath.
// Depends on jpr_pkg, jpr_ctrl, jpr_datapath.
//
// One transaction carries one packet byte or a bias command. The last byte
// starts checking, float decode and four axis normalizations, which run one
// after another through a single 32-step shift-subtract divider; an axis that
// needs no divide skips it. The result is offered after the load step and the
// four axis normalizations; input is stalled meanwhile. Results wait in
// registers until taken. Rejected packets repeat the last accepted values.
module joystick_packet_receiver_unit import jpr_pkg::*; #(
  parameter int unsigned PACKET_BYTES = 25
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  in_item_t               in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_item_t              out_item_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [CfgWidth-1:0]    cfg_data_i
);
  logic [23:0] node_address_q;
  logic        check_enable_q;
  logic [14:0] dead_zone_q;
  dp_cmd_t     dp_cmd;
  dp_stat_t    dp_stat;
  out_item_t   res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_address_q <= '0;
      check_enable_q <= 1'b1;
      dead_zone_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegNodeAddress: node_address_q <= cfg_data_i[23:0];
        RegCheckEnable: check_enable_q <= cfg_data_i[0];
        RegDeadZone:    dead_zone_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  jpr_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid_i),
    .in_item_i(in_item_i),
    .in_stall_o(in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stat_i(dp_stat),
    .cmd_o(dp_cmd)
  );

  jpr_datapath #(.PACKET_BYTES(PACKET_BYTES)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(dp_cmd),
    .item_i(in_item_i),
    .node_address_i(node_address_q),
    .check_enable_i(check_enable_q),
    .dead_zone_i(dead_zone_q),
    .stat_o(dp_stat),
    .result_o(res)
  );

  assign out_item_o = res;

`ifndef ASSERT_OFF
  // no new transaction taken while a result is pending
  a_stall_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open with result pending");
  // result payload holds while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o)) else $error("result changed");
  // status is a defined code
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.status != StatusUnused) else $error("bad status");
`endif
endmodule
